// ===== src/rlm_pkg.sv =====
// Shared types and codes for the resource lock manager.
`default_nettype none
package rlm_pkg;

  localparam int CLIENT_W = 4;
  localparam int RES_W_IN = 4;
  localparam int EVENT_W  = 3;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [EVENT_W-1:0] EV_GRANT       = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ACK         = 3'd1;
  localparam logic [EVENT_W-1:0] EV_NOT_OWNED   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_OTHER_OWNER = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SLOT_BUSY   = 3'd4;

  typedef struct packed {
    logic                operation;
    logic [CLIENT_W-1:0] client_id;
    logic [RES_W_IN-1:0] resource_index;
  } req_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t item;
  } queue_head_t;

endpackage
`default_nettype wire

// ===== src/rlm_ifs.sv =====
// Request and result channel interfaces.
`default_nettype none
interface rlm_req_if import rlm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [CLIENT_W-1:0] client_id;
  logic [RES_W_IN-1:0] resource_index;

  modport source(output valid, operation, client_id, resource_index, input ready);
  modport sink(input valid, operation, client_id, resource_index, output ready);
endinterface

interface rlm_rsp_if import rlm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_res;
  logic [CLIENT_W-1:0] target_client;
  logic [RES_W_IN-1:0] resource_number;
  logic [CLIENT_W-1:0] current_owner;
  logic                last;

  modport source(output valid, event_res, target_client, resource_number, current_owner,
                 last, input ready);
  modport sink(input valid, event_res, target_client, resource_number, current_owner,
               last, output ready);
endinterface
`default_nettype wire

// ===== src/rlm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/rlm_front.sv =====
// Front end: accepts requests, drops out-of-range ones, and queues the rest.
`default_nettype none
module rlm_front import rlm_pkg::*; #(
  parameter int NUM_RESOURCES = 16,
  parameter int NUM_CLIENTS   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rlm_req_if.sink    req,
  output queue_head_t head,
  input  wire logic  pop
);

  req_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       in_range;
  logic       push;

  // Compare at nine bits so that any parameter value up to 256 fits.
  assign in_range = ({5'b0, req.resource_index} < 9'(NUM_RESOURCES)) &&
                    ({5'b0, req.client_id} < 9'(NUM_CLIENTS));

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready && in_range;

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{operation: req.operation, client_id: req.client_id,
                     resource_index: req.resource_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/rlm_back.sv =====
// Back end: looks up lock state, updates it, and drives the result register.
`default_nettype none
module rlm_back import rlm_pkg::*; #(
  parameter int NUM_RESOURCES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire queue_head_t head,
  output logic            pop,
  rlm_rsp_if.source       rsp
);

  localparam int RES_W = $clog2(NUM_RESOURCES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  req_t       cur;

  logic [NUM_RESOURCES-1:0] held_flag;
  logic [NUM_RESOURCES-1:0] held_flag_next;
  logic [NUM_RESOURCES-1:0] waiting_flag;
  logic [NUM_RESOURCES-1:0] waiting_flag_next;

  logic [8:0]              head_wide;
  logic [8:0]              cur_wide;
  logic [RES_W-1:0]        raddr;
  logic [RES_W-1:0]        idx;
  logic [2*CLIENT_W-1:0]   rdata;
  logic [2*CLIENT_W-1:0]   wdata;
  logic                    we;
  logic [CLIENT_W-1:0]     holder;
  logic [CLIENT_W-1:0]     waiter;
  logic                    held;
  logic                    waiting;

  logic                out_valid;
  logic [EVENT_W-1:0]  out_event;
  logic [CLIENT_W-1:0] out_target;
  logic [RES_W_IN-1:0] out_res;
  logic [CLIENT_W-1:0] out_owner;
  logic                out_last;
  logic                out_free;

  logic                load;
  logic [EVENT_W-1:0]  ld_event;
  logic [CLIENT_W-1:0] ld_target;
  logic [CLIENT_W-1:0] ld_owner;
  logic                ld_last;
  logic                park;
  logic                exec_go;
  logic                handover;
  logic [CLIENT_W-1:0] sec_client;

  assign head_wide = 9'(head.item.resource_index);
  assign raddr     = head_wide[RES_W-1:0];
  assign cur_wide  = 9'(cur.resource_index);
  assign idx       = cur_wide[RES_W-1:0];

  assign pop = (state == ST_IDLE) && head.valid;

  // Each word holds the holder id in the upper half and the waiter id below.
  rlm_ram #(.WIDTH(2*CLIENT_W), .DEPTH(NUM_RESOURCES)) u_ids (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .re    (pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign holder   = rdata[2*CLIENT_W-1:CLIENT_W];
  assign waiter   = rdata[CLIENT_W-1:0];
  assign held     = held_flag[idx];
  assign waiting  = waiting_flag[idx];
  assign out_free = !out_valid || rsp.ready;

  // Parking a waiter yields no result, so it need not wait for the output.
  assign park    = (cur.operation == OP_ACQUIRE) && held && !waiting;
  assign exec_go = (state == ST_EXEC) && (out_free || park);

  always_comb begin
    state_next        = state;
    held_flag_next    = held_flag;
    waiting_flag_next = waiting_flag;
    we                = 1'b0;
    wdata             = rdata;
    load              = 1'b0;
    ld_event          = EV_GRANT;
    ld_target         = cur.client_id;
    ld_owner          = cur.client_id;
    ld_last           = 1'b1;
    handover          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
          if (cur.operation == OP_ACQUIRE) begin
            if (!held) begin
              held_flag_next[idx] = 1'b1;
              we    = 1'b1;
              wdata = {cur.client_id, waiter};
              load  = 1'b1;
            end else if (waiting) begin
              load     = 1'b1;
              ld_event = EV_SLOT_BUSY;
              ld_owner = holder;
            end else begin
              waiting_flag_next[idx] = 1'b1;
              we    = 1'b1;
              wdata = {holder, cur.client_id};
            end
          end else begin
            load = 1'b1;
            if (!held) begin
              ld_event = EV_NOT_OWNED;
              ld_owner = '0;
            end else if (holder != cur.client_id) begin
              ld_event = EV_OTHER_OWNER;
              ld_owner = holder;
            end else if (!waiting) begin
              held_flag_next[idx] = 1'b0;
              ld_event = EV_ACK;
              ld_owner = '0;
            end else begin
              waiting_flag_next[idx] = 1'b0;
              we         = 1'b1;
              wdata      = {waiter, waiter};
              ld_event   = EV_ACK;
              ld_owner   = waiter;
              ld_last    = 1'b0;
              handover   = 1'b1;
              state_next = ST_SECOND;
            end
          end
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          load       = 1'b1;
          ld_event   = EV_GRANT;
          ld_target  = sec_client;
          ld_owner   = sec_client;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held_flag    <= '0;
      waiting_flag <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      held_flag    <= held_flag_next;
      waiting_flag <= waiting_flag_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
    end
    if (handover) begin
      sec_client <= waiter;
    end
    if (load) begin
      out_event  <= ld_event;
      out_target <= ld_target;
      out_res    <= cur.resource_index;
      out_owner  <= ld_owner;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.event_res       = out_event;
  assign rsp.target_client   = out_target;
  assign rsp.resource_number = out_res;
  assign rsp.current_owner   = out_owner;
  assign rsp.last            = out_last;

`ifndef SYNTH
  // While the handover grant is pending, the acknowledge still sits in the output.
  a_second_after_ack: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECOND) |-> (out_valid && !out_last && out_event == EV_ACK))
    else $error("handover grant pending without its acknowledge");

  // Only the acknowledge of a handover is followed by another result.
  a_nonlast_is_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_event == EV_ACK))
    else $error("non-final result is not an acknowledge");

  // A waiter is never parked on a resource that nobody holds.
  a_waiter_needs_holder: assert property (@(posedge clk) disable iff (rst)
    ((waiting_flag & ~held_flag) == '0))
    else $error("waiter parked on a free resource");

  // The queue is popped only when the previous item has fully left the update stage.
  a_pop_after_update: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_EXEC))
    else $error("popped item did not enter the update stage");
`endif

endmodule
`default_nettype wire

// ===== src/resource_lock_manager_single_waiter.sv =====
// Results pass the two-entry queue, the registered id RAM read and the update state.
// The back end takes a new request only after the last one leaves the update state,
// which waits for a free output unless it parks a waiter; a handover adds a grant state.
// A two-entry queue decouples request acceptance from the update stage.
// Reset clears the held and waiting flags at once; the id RAM is not cleared and
// needs no clearing pass, so requests are accepted right after reset.
`default_nettype none
module resource_lock_manager_single_waiter import rlm_pkg::*; #(
  parameter int NUM_RESOURCES = 16,
  parameter int NUM_CLIENTS   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rlm_req_if.sink   req,
  rlm_rsp_if.source rsp
);

  queue_head_t head;
  logic        pop;

  rlm_front #(.NUM_RESOURCES(NUM_RESOURCES), .NUM_CLIENTS(NUM_CLIENTS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  rlm_back #(.NUM_RESOURCES(NUM_RESOURCES)) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire
